### sv/trb_enq_pkg.sv
// ----------------------------------------------------------------------------
// trb_enq_pkg
// Shared codes, constants and control structs for the TRB ring enqueue unit.
// ----------------------------------------------------------------------------
package trb_enq_pkg;

	localparam int unsigned SIZE_W     = 9;
	localparam int unsigned ADDR_W     = 64;
	localparam int unsigned DWORD_W    = 32;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned COUNT_W    = 9;

	localparam logic [SIZE_W-1:0]  MIN_SLOTS     = 9'd16;
	localparam logic [DWORD_W-1:0] LINK_DW3_BASE = (32'd6 << 10) | 32'd2;

	typedef enum logic [1:0] {
		KIND_ENQUEUE  = 2'd0,
		KIND_COMPLETE = 2'd1,
		KIND_START    = 2'd2,
		KIND_UNUSED   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_FULL        = 2'd1,
		STAT_NOT_STARTED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		WK_NONE   = 2'd0,
		WK_ALL    = 2'd1,
		WK_DWORD3 = 2'd2
	} write_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RING_SIZE = 1'd0,
		REG_RING_BASE = 1'd1
	} cfg_reg_t;

	typedef struct packed {
		logic load_item;
		logic load_link;
	} enq_cmd_t;

	typedef struct packed {
		logic link_pend;
	} enq_stat_t;

endpackage

### sv/trb_enq_ctrl.sv
// ----------------------------------------------------------------------------
// trb_enq_ctrl
// Handshake controller: accepts beats, sequences one or two result beats.
// ----------------------------------------------------------------------------
module trb_enq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  trb_enq_pkg::enq_stat_t dp_stat,
	output trb_enq_pkg::enq_cmd_t  dp_cmd
);
	import trb_enq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_OUT1 = 3'b010,
		ST_OUT2 = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   in_fire;
	logic   out_fire;

	assign out_valid = (state_q != ST_IDLE);
	assign out_fire  = out_valid & ~out_stall;
	assign in_stall  = ~((state_q == ST_IDLE) | (out_fire & ~dp_stat.link_pend));
	assign in_fire   = in_valid & ~in_stall;

	assign dp_cmd.load_item = in_fire;
	assign dp_cmd.load_link = out_fire & dp_stat.link_pend;

	always_comb begin
		state_nxt = state_q;
		if (in_fire) begin
			state_nxt = ST_OUT1;
		end else if (out_fire & dp_stat.link_pend) begin
			state_nxt = ST_OUT2;
		end else if (out_fire) begin
			state_nxt = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_fire_shows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid && state_q == ST_OUT1)
		else $error("accepted beat not presented");

	a_out2_after_out1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_OUT2) |-> $past(state_q == ST_OUT1))
		else $error("link beat without preceding slot beat");

	a_no_accept_on_link: assert property (@(posedge clk) disable iff (!arst_n)
		dp_stat.link_pend |-> in_stall)
		else $error("accept while link beat pending");

	a_idle_no_link: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !dp_stat.link_pend)
		else $error("link pending in idle");

endmodule

### sv/trb_enq_dp.sv
// ----------------------------------------------------------------------------
// trb_enq_dp
// Ring state, config registers and result registers of the enqueue unit.
// ----------------------------------------------------------------------------
module trb_enq_dp #(
	parameter int unsigned MAX_SLOTS = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [trb_enq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [trb_enq_pkg::ADDR_W-1:0]       cfg_data,
	input  trb_enq_pkg::enq_cmd_t                dp_cmd,
	output trb_enq_pkg::enq_stat_t               dp_stat,
	input  logic [1:0]                           kind,
	input  logic [trb_enq_pkg::DWORD_W-1:0]      trb_word0,
	input  logic [trb_enq_pkg::DWORD_W-1:0]      trb_word1,
	input  logic [trb_enq_pkg::DWORD_W-1:0]      trb_word2,
	input  logic [trb_enq_pkg::DWORD_W-1:0]      trb_word3,
	input  logic [trb_enq_pkg::COUNT_W-1:0]      complete_count,
	output logic [1:0]                           status,
	output logic [1:0]                           write_kind,
	output logic [7:0]                           slot,
	output logic [trb_enq_pkg::ADDR_W-1:0]       trb_address,
	output logic [trb_enq_pkg::DWORD_W-1:0]      out_word0,
	output logic [trb_enq_pkg::DWORD_W-1:0]      out_word1,
	output logic [trb_enq_pkg::DWORD_W-1:0]      out_word2,
	output logic [trb_enq_pkg::DWORD_W-1:0]      out_word3,
	output logic [7:0]                           pending,
	output logic                                 last
);
	import trb_enq_pkg::*;

	localparam logic [31:0] MAX_SLOTS_L = 32'(MAX_SLOTS);

	// config
	logic [SIZE_W-1:0]  ring_size_q;
	logic [ADDR_W-1:0]  ring_base_q;

	// ring state
	logic [SIZE_W-1:0]  idx_q;
	logic               cycle_q;
	logic [COUNT_W-1:0] pend_q;
	logic               started_q;
	logic               link_pend_q;

	// result registers
	logic [1:0]         status_q;
	logic [1:0]         wk_q;
	logic [7:0]         slot_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [DWORD_W-1:0] w0_q, w1_q, w2_q, w3_q;
	logic               last_q;

	logic [SIZE_W-1:0]  size;
	logic [SIZE_W-1:0]  link;
	logic [SIZE_W-1:0]  cur_slot;
	logic [SIZE_W-1:0]  next_slot;
	logic               wrap;

	logic [1:0]         n_status;
	logic [1:0]         n_wk;
	logic [SIZE_W-1:0]  n_slot;
	logic [DWORD_W-1:0] n_w0, n_w1, n_w2, n_w3;
	logic               n_last;
	logic [SIZE_W-1:0]  n_idx;
	logic               n_cycle;
	logic [COUNT_W-1:0] n_pend;
	logic               n_started;
	logic               n_link_pend;
	logic [ADDR_W-1:0]  n_addr;

	always_comb begin
		size = ring_size_q;
		if (ring_size_q < MIN_SLOTS) begin
			size = MIN_SLOTS;
		end
		if ({23'd0, ring_size_q} > MAX_SLOTS_L) begin
			size = MAX_SLOTS_L[SIZE_W-1:0];
		end
	end

	assign link      = size - 9'd1;
	assign cur_slot  = (idx_q >= link) ? '0 : idx_q;
	assign next_slot = cur_slot + 9'd1;
	assign wrap      = (next_slot >= link);

	always_comb begin
		n_status    = STAT_OK;
		n_wk        = WK_NONE;
		n_slot      = '0;
		n_w0        = '0;
		n_w1        = '0;
		n_w2        = '0;
		n_w3        = '0;
		n_last      = 1'b1;
		n_idx       = idx_q;
		n_cycle     = cycle_q;
		n_pend      = pend_q;
		n_started   = started_q;
		n_link_pend = 1'b0;
		case (kind)
			KIND_START: begin
				n_idx     = '0;
				n_cycle   = 1'b1;
				n_pend    = '0;
				n_started = 1'b1;
				n_wk      = WK_ALL;
				n_slot    = link;
				n_w0      = ring_base_q[31:0];
				n_w1      = ring_base_q[63:32];
				n_w3      = LINK_DW3_BASE | 32'd1;
			end
			KIND_COMPLETE: begin
				n_pend = (complete_count >= pend_q) ? '0 : pend_q - complete_count;
			end
			KIND_ENQUEUE: begin
				if (!started_q) begin
					n_status = STAT_NOT_STARTED;
				end else if (pend_q >= size - 9'd2) begin
					n_status = STAT_FULL;
				end else begin
					n_wk        = WK_ALL;
					n_slot      = cur_slot;
					n_w0        = trb_word0;
					n_w1        = trb_word1;
					n_w2        = trb_word2;
					n_w3        = {trb_word3[31:1], cycle_q};
					n_pend      = pend_q + 9'd1;
					n_last      = ~wrap;
					n_link_pend = wrap;
					n_idx       = wrap ? '0 : next_slot;
					n_cycle     = wrap ? ~cycle_q : cycle_q;
				end
			end
			default: begin
			end
		endcase
	end

	// one adder serves both the slot beat and the link rewrite beat
	always_comb begin
		if (dp_cmd.load_link) begin
			n_addr = ring_base_q + {51'd0, link, 4'd0};
		end else if (n_wk != WK_NONE) begin
			n_addr = ring_base_q + {51'd0, n_slot, 4'd0};
		end else begin
			n_addr = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= 9'd256;
			ring_base_q <= '0;
			idx_q       <= '0;
			cycle_q     <= 1'b1;
			pend_q      <= '0;
			started_q   <= 1'b0;
			link_pend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RING_SIZE: ring_size_q <= cfg_data[SIZE_W-1:0];
					REG_RING_BASE: ring_base_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (dp_cmd.load_item) begin
				idx_q       <= n_idx;
				cycle_q     <= n_cycle;
				pend_q      <= n_pend;
				started_q   <= n_started;
				link_pend_q <= n_link_pend;
			end else if (dp_cmd.load_link) begin
				link_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load_item) begin
			status_q <= n_status;
			wk_q     <= n_wk;
			slot_q   <= n_slot[7:0];
			addr_q   <= n_addr;
			w0_q     <= n_w0;
			w1_q     <= n_w1;
			w2_q     <= n_w2;
			w3_q     <= n_w3;
			last_q   <= n_last;
		end else if (dp_cmd.load_link) begin
			// cycle already toggled, link dword3 carries the cycle before the wrap
			status_q <= STAT_OK;
			wk_q     <= WK_DWORD3;
			slot_q   <= link[7:0];
			addr_q   <= n_addr;
			w0_q     <= '0;
			w1_q     <= '0;
			w2_q     <= '0;
			w3_q     <= LINK_DW3_BASE | {31'd0, ~cycle_q};
			last_q   <= 1'b1;
		end
	end

	assign dp_stat.link_pend = link_pend_q;

	assign status      = status_q;
	assign write_kind  = wk_q;
	assign slot        = slot_q;
	assign trb_address = addr_q;
	assign out_word0   = w0_q;
	assign out_word1   = w1_q;
	assign out_word2   = w2_q;
	assign out_word3   = w3_q;
	assign pending     = pend_q[7:0];
	assign last        = last_q;

	a_started_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q)
		else $error("started flag cleared");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load_item && kind == KIND_ENQUEUE && n_wk == WK_ALL |-> pend_q < size - 9'd2)
		else $error("enqueue into full ring");

	a_wrap_resets_idx: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load_item && n_link_pend |=> idx_q == '0 && cycle_q != $past(cycle_q))
		else $error("wrap did not rewind producer");

endmodule

### sv/trb_producer_ring_enqueue_unit.sv
// ----------------------------------------------------------------------------
// trb_producer_ring_enqueue_unit
// Producer side of a TRB ring: start, enqueue with cycle bit and link rewrite,
// completion accounting.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   in       | in_valid / in_stall | kind, trb_word0..3, complete_count
//   out      | out_valid/out_stall | status, write_kind, slot, trb_address,
//            |                     | out_word0..3, pending, last
//   cfg      | cfg_we              | cfg_index, cfg_data
//
// An accepted beat is registered and shown as a result beat the next cycle.
// A new beat is taken in the same cycle the last result beat leaves, so one
// item per cycle is sustained while out_stall is low; a wrapping enqueue
// adds the link TRB rewrite beat. The 64-bit slot address adder sets the path.
// Reset returns producer slot 0, cycle 1, nothing pending, ring not started.
// Output stall holds the result registers and stalls the input.
// ----------------------------------------------------------------------------
module trb_producer_ring_enqueue_unit #(
	parameter int unsigned MAX_SLOTS = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [trb_enq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [trb_enq_pkg::ADDR_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           kind,
	input  logic [trb_enq_pkg::DWORD_W-1:0]      trb_word0,
	input  logic [trb_enq_pkg::DWORD_W-1:0]      trb_word1,
	input  logic [trb_enq_pkg::DWORD_W-1:0]      trb_word2,
	input  logic [trb_enq_pkg::DWORD_W-1:0]      trb_word3,
	input  logic [trb_enq_pkg::COUNT_W-1:0]      complete_count,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           status,
	output logic [1:0]                           write_kind,
	output logic [7:0]                           slot,
	output logic [trb_enq_pkg::ADDR_W-1:0]       trb_address,
	output logic [trb_enq_pkg::DWORD_W-1:0]      out_word0,
	output logic [trb_enq_pkg::DWORD_W-1:0]      out_word1,
	output logic [trb_enq_pkg::DWORD_W-1:0]      out_word2,
	output logic [trb_enq_pkg::DWORD_W-1:0]      out_word3,
	output logic [7:0]                           pending,
	output logic                                 last
);
	import trb_enq_pkg::*;

	enq_cmd_t  dp_cmd;
	enq_stat_t dp_stat;

	trb_enq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_stat   (dp_stat),
		.dp_cmd    (dp_cmd)
	);

	trb_enq_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.dp_cmd         (dp_cmd),
		.dp_stat        (dp_stat),
		.kind           (kind),
		.trb_word0      (trb_word0),
		.trb_word1      (trb_word1),
		.trb_word2      (trb_word2),
		.trb_word3      (trb_word3),
		.complete_count (complete_count),
		.status         (status),
		.write_kind     (write_kind),
		.slot           (slot),
		.trb_address    (trb_address),
		.out_word0      (out_word0),
		.out_word1      (out_word1),
		.out_word2      (out_word2),
		.out_word3      (out_word3),
		.pending        (pending),
		.last           (last)
	);

endmodule

### dv/tb_trb_producer_ring_enqueue_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trb_producer_ring_enqueue_unit
// Self-checking bench for the TRB producer ring enqueue unit.
// A queue-fed driver offers command beats with random gaps. A ring model
// predicts every result beat when a command is accepted. A monitor with
// random and long output stalls checks each result beat field by field.
// Ring size and base are reprogrammed between phases, with out-of-range sizes,
// the 16 and 256 slot extremes and resizes while the ring is running.
// ----------------------------------------------------------------------------
module tb_trb_producer_ring_enqueue_unit;
	import trb_enq_pkg::*;

	localparam int unsigned MAX_SLOTS  = 256;
	localparam int unsigned IDLE_LIMIT = 3000;
	localparam int unsigned RAND_ITEMS = 60;

	typedef struct {
		kind_t       kind;
		logic [31:0] w0, w1, w2, w3;
		logic [8:0]  cnt;
	} trb_cmd_t;

	typedef struct {
		status_t     status;
		write_kind_t wk;
		logic [7:0]  slot;
		logic [63:0] addr;
		logic [31:0] w0, w1, w2, w3;
		logic [7:0]  pend;
		logic        last;
	} ring_write_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           kind = '0;
	logic [DWORD_W-1:0]   trb_word0 = '0;
	logic [DWORD_W-1:0]   trb_word1 = '0;
	logic [DWORD_W-1:0]   trb_word2 = '0;
	logic [DWORD_W-1:0]   trb_word3 = '0;
	logic [COUNT_W-1:0]   complete_count = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           status;
	logic [1:0]           write_kind;
	logic [7:0]           slot;
	logic [ADDR_W-1:0]    trb_address;
	logic [DWORD_W-1:0]   out_word0;
	logic [DWORD_W-1:0]   out_word1;
	logic [DWORD_W-1:0]   out_word2;
	logic [DWORD_W-1:0]   out_word3;
	logic [7:0]           pending;
	logic                 last;

	trb_producer_ring_enqueue_unit #(.MAX_SLOTS(MAX_SLOTS)) dut (.*);

	// ring model state and register copies
	logic [8:0]  cfg_size = 9'd256;
	logic [63:0] cfg_base = '0;
	int unsigned prod_slot = 0;
	logic        prod_cycle = 1'b1;
	int unsigned outstanding = 0;
	logic        ring_on = 1'b0;

	trb_cmd_t    trb_cmd_q[$];
	ring_write_t ring_writes_due[$];
	trb_cmd_t    cur_cmd;

	int unsigned n_issued = 0, n_in = 0, n_out = 0, n_errors = 0;
	int unsigned n_wraps = 0, n_full = 0, n_settings = 1;
	int unsigned gap_left = 0, stall_left = 0, idle_cycles = 0;
	logic        quiet = 1'b0, hold_req = 1'b0, hold_taken = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic predict_ring_writes(input trb_cmd_t c);
		int unsigned sz, lnk, s;
		logic        cy;
		logic        wrap;
		ring_write_t r, blank;
		blank = '{STAT_OK, WK_NONE, 8'd0, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0, 1'b1};
		sz = cfg_size;
		if (sz < MIN_SLOTS) sz = MIN_SLOTS;
		if (sz > MAX_SLOTS) sz = MAX_SLOTS;
		lnk = sz - 1;
		r = blank;
		case (c.kind)
			KIND_START: begin
				prod_slot = 0;
				prod_cycle = 1'b1;
				outstanding = 0;
				ring_on = 1'b1;
				r.wk = WK_ALL;
				r.slot = lnk[7:0];
				r.addr = cfg_base + 64'(lnk) * 64'd16;
				r.w0 = cfg_base[31:0];
				r.w1 = cfg_base[63:32];
				r.w3 = LINK_DW3_BASE | 32'd1;
			end
			KIND_COMPLETE: begin
				outstanding = (c.cnt >= outstanding) ? 0 : outstanding - c.cnt;
			end
			KIND_ENQUEUE: begin
				if (!ring_on) begin
					r.status = STAT_NOT_STARTED;
				end else if (outstanding >= sz - 2) begin
					r.status = STAT_FULL;
					n_full++;
				end else begin
					// resized below the producer slot: fold back without a toggle
					if (prod_slot >= lnk) prod_slot = 0;
					s = prod_slot;
					cy = prod_cycle;
					outstanding++;
					prod_slot = s + 1;
					wrap = (prod_slot >= lnk);
					r.wk = WK_ALL;
					r.slot = s[7:0];
					r.addr = cfg_base + 64'(s) * 64'd16;
					r.w0 = c.w0;
					r.w1 = c.w1;
					r.w2 = c.w2;
					r.w3 = {c.w3[31:1], cy};
					r.pend = outstanding[7:0];
					r.last = !wrap;
					if (wrap) begin
						ring_writes_due.push_back(r);
						r = blank;
						r.wk = WK_DWORD3;
						r.slot = lnk[7:0];
						r.addr = cfg_base + 64'(lnk) * 64'd16;
						r.w3 = LINK_DW3_BASE | {31'd0, cy};
						prod_slot = 0;
						prod_cycle = ~cy;
						n_wraps++;
					end
				end
			end
			default: ;
		endcase
		r.pend = outstanding[7:0];
		ring_writes_due.push_back(r);
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		trb_cmd_t c;
		logic     nvalid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_ENQUEUE;
			trb_word0 <= '0;
			trb_word1 <= '0;
			trb_word2 <= '0;
			trb_word3 <= '0;
			complete_count <= '0;
			gap_left = 0;
		end else begin
			nvalid = in_valid;
			if (in_valid && !in_stall) begin
				predict_ring_writes(cur_cmd);
				n_in++;
				nvalid = 1'b0;
			end
			if (!nvalid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (trb_cmd_q.size() > 0) begin
					c = trb_cmd_q.pop_front();
					cur_cmd = c;
					kind <= c.kind;
					trb_word0 <= c.w0;
					trb_word1 <= c.w1;
					trb_word2 <= c.w2;
					trb_word3 <= c.w3;
					complete_count <= c.cnt;
					nvalid = 1'b1;
					gap_left = pick_gap();
				end
			end
			in_valid <= nvalid;
		end
	end

	task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
		if (e !== a) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, e, a);
			n_errors++;
		end
	endtask

	// monitor
	always @(posedge clk or negedge arst_n) begin
		ring_write_t e;
		int unsigned r;
		logic        nstall;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_out++;
				if (ring_writes_due.size() == 0) begin
					$error("result beat with nothing expected");
					n_errors++;
				end else begin
					e = ring_writes_due.pop_front();
					check_field("status", e.status, status);
					check_field("write_kind", e.wk, write_kind);
					check_field("slot", e.slot, slot);
					check_field("trb_address", e.addr, trb_address);
					check_field("out_word0", e.w0, out_word0);
					check_field("out_word1", e.w1, out_word1);
					check_field("out_word2", e.w2, out_word2);
					check_field("out_word3", e.w3, out_word3);
					check_field("pending", e.pend, pending);
					check_field("last", e.last, last);
				end
			end
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				stall_left = 120;
			end
			if (stall_left > 0) begin
				stall_left--;
				nstall = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				nstall = !(quiet || r < 70);
				if (nstall) stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
			end
			out_stall <= nstall;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	function automatic trb_cmd_t mk_cmd(input kind_t k, input logic [31:0] w0, input logic [31:0] w1,
			input logic [31:0] w2, input logic [31:0] w3, input logic [8:0] cnt);
		trb_cmd_t c;
		c.kind = k;
		c.w0 = w0;
		c.w1 = w1;
		c.w2 = w2;
		c.w3 = w3;
		c.cnt = cnt;
		return c;
	endfunction

	function automatic trb_cmd_t rand_cmd();
		trb_cmd_t    c;
		int unsigned r;
		c = mk_cmd(KIND_ENQUEUE, $urandom, $urandom, $urandom, $urandom, 9'($urandom_range(0, 3)));
		r = $urandom_range(0, 99);
		if (r >= 64 && r < 88) begin
			c.kind = KIND_COMPLETE;
			r = $urandom_range(0, 9);
			if (r < 2) c.cnt = 9'($urandom_range(0, 256));
			else if (r == 2) c.cnt = 9'd256;
		end else if (r >= 88 && r < 93) begin
			c.kind = KIND_START;
		end else if (r >= 93 && r < 96) begin
			c.kind = KIND_UNUSED;
		end
		return c;
	endfunction

	task automatic queue_cmd(input trb_cmd_t c);
		trb_cmd_q.push_back(c);
		n_issued++;
	endtask

	task automatic drain();
		do @(negedge clk); while (n_in != n_issued || ring_writes_due.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RING_SIZE) cfg_size = d[8:0];
		else cfg_base = d;
		@(negedge clk);
	endtask

	initial begin
		int unsigned sizes [9];
		logic [63:0] base;
		sizes = '{16, 17, 40, 0, 300, 255, 256, 16, 511};
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset settings: before start, unused kind, first enqueues
		queue_cmd(mk_cmd(KIND_ENQUEUE, '1, '1, '1, '1, 9'd0));
		queue_cmd(mk_cmd(KIND_UNUSED, '1, '1, '1, '1, 9'd511));
		queue_cmd(mk_cmd(KIND_COMPLETE, '0, '0, '0, '0, 9'd256));
		queue_cmd(mk_cmd(KIND_START, '0, '0, '0, '0, 9'd0));
		queue_cmd(mk_cmd(KIND_ENQUEUE, '0, '0, '0, '0, 9'd0));
		queue_cmd(mk_cmd(KIND_ENQUEUE, '1, '1, '1, '1, 9'd0));
		drain();

		// smallest ring near the top of the address space: fill, full, wrap
		write_reg(REG_RING_SIZE, 64'd16);
		write_reg(REG_RING_BASE, 64'hFFFF_FFFF_FFFF_FFC0);
		n_settings++;
		queue_cmd(mk_cmd(KIND_START, '0, '0, '0, '0, 9'd0));
		repeat (15) queue_cmd(mk_cmd(KIND_ENQUEUE, $urandom, $urandom, $urandom, $urandom, 9'd0));
		queue_cmd(mk_cmd(KIND_COMPLETE, '0, '0, '0, '0, 9'd1));
		queue_cmd(mk_cmd(KIND_ENQUEUE, $urandom, $urandom, $urandom, 32'hFFFF_FFFE, 9'd0));
		queue_cmd(mk_cmd(KIND_ENQUEUE, $urandom, $urandom, $urandom, $urandom, 9'd0));
		queue_cmd(mk_cmd(KIND_COMPLETE, '0, '0, '0, '0, 9'd256));
		queue_cmd(mk_cmd(KIND_ENQUEUE, $urandom, $urandom, $urandom, 32'hFFFF_FFFF, 9'd0));
		drain();

		for (int i = 0; i < 9; i++) begin
			base = {$urandom, $urandom} & ~64'h3F;
			if (i == 3) base = '1;
			write_reg(REG_RING_SIZE, 64'(sizes[i]));
			write_reg(REG_RING_BASE, base);
			n_settings++;
			if (i % 4 == 0) queue_cmd(mk_cmd(KIND_START, '0, '0, '0, '0, 9'd0));
			quiet = (i == 4 || i == 7);
			repeat (RAND_ITEMS) queue_cmd(rand_cmd());
			// long output hold with the sender still busy
			if (i == 4) hold_req = 1'b1;
			drain();
			quiet = 1'b0;
		end

		repeat (10) @(posedge clk);
		$display("covered %0d command beats, %0d result beats, %0d ring settings",
			n_in, n_out, n_settings);
		$display("ring wraps %0d, full rejects %0d", n_wraps, n_full);
		if (n_errors == 0 && ring_writes_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
